// File: src/light_sensor_detect_calibrate_normalize_macros.svh
// ----------------------------------------------------------------------------
// Light sensor assertion macros
// Shared concurrent assertion forms for the light sensor block.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_DETECT_CALIBRATE_NORMALIZE_MACROS_SVH
`define LIGHT_SENSOR_DETECT_CALIBRATE_NORMALIZE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LSDCN_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSDCN_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lsdcn_pkg.sv
// ----------------------------------------------------------------------------
// lsdcn_pkg
// Types and constants shared by the light sensor block.
// ----------------------------------------------------------------------------
package lsdcn_pkg;

  localparam int SAMPLE_W = 12;
  localparam int BOUND_W  = 16;
  localparam int CNT_W    = 5;
  localparam int SUM_W    = 16;
  localparam int Q_W      = 16;
  localparam int NUMER_W  = SAMPLE_W + Q_W;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd100;
  localparam logic [SAMPLE_W-1:0] FLOOR_RST     = 12'd50;
  localparam logic [SAMPLE_W-1:0] SPAN_RST      = 12'd100;
  localparam logic [BOUND_W-1:0]  DEFMAX_RST    = 16'd1023;
  localparam logic [SAMPLE_W-1:0] MIN_RST       = 12'hFFF;
  localparam logic [Q_W-1:0]      NORM_MID      = 16'h8000;
  localparam logic [Q_W-1:0]      NORM_FULL     = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_DETECT = 2'd0,
    PH_CALIB  = 2'd1,
    PH_RUN    = 2'd2,
    PH_NONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_MANUAL  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_DETECT_THRESHOLD = 2'd0,
    REG_CALIB_FLOOR      = 2'd1,
    REG_CALIB_SPAN       = 2'd2,
    REG_DEFAULT_MAX      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_DIV   = 2'd2,
    ST_EMIT  = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] detect_threshold;
    logic [SAMPLE_W-1:0] calib_floor;
    logic [SAMPLE_W-1:0] calib_span;
    logic [BOUND_W-1:0]  default_max;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_sts_t;

endpackage

// File: src/lsdcn_if.sv
// ----------------------------------------------------------------------------
// lsdcn channel interfaces
// Valid/ready channels for sensor items and result items.
// ----------------------------------------------------------------------------
interface lsdcn_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] sample;
  logic [15:0] manual_low;
  logic [15:0] manual_high;

  modport source(output valid, action, sample, manual_low, manual_high, input ready);
  modport sink(input valid, action, sample, manual_low, manual_high, output ready);
endinterface

interface lsdcn_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic        connected;
  logic        updated;
  logic [11:0] level;
  logic [15:0] normalized;
  logic [15:0] pupil_factor;

  modport source(output valid, phase, connected, updated, level, normalized,
                 pupil_factor, input ready);
  modport sink(input valid, phase, connected, updated, level, normalized,
               pupil_factor, output ready);
endinterface

// File: src/lsdcn_div.sv
// ----------------------------------------------------------------------------
// lsdcn_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "light_sensor_detect_calibrate_normalize_macros.svh"

module lsdcn_div
  import lsdcn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUMER_W-1:0] numer,
  input  logic [Q_W-1:0]     denom,
  output logic               done,
  output logic [Q_W-1:0]     quot
);

  localparam int STEP_W = $clog2(Q_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);

  // numer[NUMER_W-1:Q_W] must be below denom so the quotient fits Q_W bits
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [Q_W-1:0]    rem;
  logic [Q_W-1:0]    work;
  logic [Q_W:0]      trial;
  logic              fits;

  assign trial = {rem, work[Q_W-1]};
  assign fits  = (trial >= {1'b0, denom});
  assign quot  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= Q_W'(numer[NUMER_W-1:Q_W]);
      work <= numer[Q_W-1:0];
    end else if (busy) begin
      rem  <= fits ? Q_W'(trial - {1'b0, denom}) : trial[Q_W-1:0];
      work <= {work[Q_W-2:0], fits};
    end
  end

  `LSDCN_ASSERT_NEXT(a_div_start_busy, clk, rst, start, busy && !done, "divider did not start")
  `LSDCN_ASSERT_IMPL(a_div_done_idle, clk, rst, done, !busy, "divider done while busy")
  `LSDCN_ASSERT_NEXT(a_div_finish, clk, rst, busy && !start && step == LAST_STEP, done,
                     "divider missed its last step")

endmodule

// File: src/lsdcn_ctrl.sv
// ----------------------------------------------------------------------------
// lsdcn_ctrl
// Sequencer: accept an item, run the divider if needed, commit the result.
// ----------------------------------------------------------------------------
`include "light_sensor_detect_calibrate_normalize_macros.svh"

module lsdcn_ctrl
  import lsdcn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;
  logic        slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.need_div) begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.commit || (out_valid && !out_ready);
  end

  `LSDCN_ASSERT_NEXT(a_ctrl_accept, clk, rst, in_valid && in_ready, state == ST_CHECK,
                     "accepted item not checked")
  `LSDCN_ASSERT_IMPL(a_ctrl_start, clk, rst, cmd.start_div, sts.need_div,
                     "divider started without need")
  `LSDCN_ASSERT_NEXT(a_ctrl_commit, clk, rst, cmd.commit, out_valid, "commit lost result")
  `LSDCN_ASSERT_NEXT(a_ctrl_div_exit, clk, rst, state == ST_DIV && sts.div_done,
                     state == ST_EMIT, "division result not emitted")

endmodule

// File: src/lsdcn_dp.sv
// ----------------------------------------------------------------------------
// lsdcn_dp
// Sensor state, bound selection, normalization and result register.
// ----------------------------------------------------------------------------
module lsdcn_dp
  import lsdcn_pkg::*;
#(
  parameter int DETECT_SAMPLES = 8,
  parameter int CALIB_SAMPLES  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [1:0]          action,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [BOUND_W-1:0]  manual_low,
  input  logic [BOUND_W-1:0]  manual_high,
  output logic [1:0]          phase,
  output logic                connected,
  output logic                updated,
  output logic [SAMPLE_W-1:0] level,
  output logic [Q_W-1:0]      normalized,
  output logic [Q_W-1:0]      pupil_factor
);

  localparam logic [CNT_W-1:0] DET_N   = CNT_W'(DETECT_SAMPLES);
  localparam logic [CNT_W-1:0] CAL_N   = CNT_W'(CALIB_SAMPLES);
  localparam logic [Q_W-1:0]   DET_DIV = Q_W'(DETECT_SAMPLES);
  localparam logic [Q_W-1:0]   CAL_DIV = Q_W'(CALIB_SAMPLES);

  // latched item
  logic [1:0]          act;
  logic [SAMPLE_W-1:0] smp;
  logic [BOUND_W-1:0]  man_lo;
  logic [BOUND_W-1:0]  man_hi;

  // sensor state
  phase_t              ph, ph_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [SUM_W-1:0]    sum, sum_next;
  logic [SAMPLE_W-1:0] run_min, run_min_next;
  logic [SAMPLE_W-1:0] run_max, run_max_next;
  logic [BOUND_W-1:0]  bound_low, bound_low_next;
  logic [BOUND_W-1:0]  bound_high, bound_high_next;
  logic [SAMPLE_W-1:0] last_level, last_level_next;

  logic [CNT_W-1:0]    cnt_inc;
  logic [SUM_W-1:0]    sum_add;
  logic [SAMPLE_W-1:0] min_new, max_new, spread;
  logic [BOUND_W-1:0]  range;
  logic                above_low;
  logic [SAMPLE_W-1:0] diff;
  logic                det_end, cal_end, run_div;
  logic [NUMER_W-1:0]  numer;
  logic [Q_W-1:0]      denom;
  logic                div_start;
  logic                div_done;
  logic [Q_W-1:0]      quot;
  logic [SAMPLE_W-1:0] avg;
  logic                upd;
  logic [Q_W-1:0]      norm;

  assign cnt_inc   = count + 1'b1;
  assign sum_add   = sum + SUM_W'(smp);
  assign min_new   = (smp < run_min) ? smp : run_min;
  assign max_new   = (smp > run_max) ? smp : run_max;
  assign spread    = max_new - min_new;
  assign range     = bound_high - bound_low;
  assign above_low = (BOUND_W'(smp) > bound_low);
  // bound_low < sample here, so it fits the sample width
  assign diff      = smp - bound_low[SAMPLE_W-1:0];
  assign avg       = quot[SAMPLE_W-1:0];

  assign det_end = (ph == PH_DETECT) && (cnt_inc >= DET_N);
  assign cal_end = (ph == PH_CALIB) && (cnt_inc >= CAL_N);
  assign run_div = (ph == PH_RUN) && (range != '0) && above_low
                   && (BOUND_W'(diff) < range);

  assign sts.need_div = (action_t'(act) == ACT_SAMPLE) && (det_end || cal_end || run_div);
  assign sts.div_done = div_done;
  assign div_start    = cmd.start_div;

  // diff * 65535 formed as (diff << 16) - diff
  always_comb begin
    if (ph == PH_RUN) begin
      numer = {diff, {Q_W{1'b0}}} - NUMER_W'(diff);
      denom = range;
    end else begin
      numer = NUMER_W'(sum_add);
      denom = (ph == PH_DETECT) ? DET_DIV : CAL_DIV;
    end
  end

  lsdcn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    ph_next         = ph;
    count_next      = count;
    sum_next        = sum;
    run_min_next    = run_min;
    run_max_next    = run_max;
    bound_low_next  = bound_low;
    bound_high_next = bound_high;
    last_level_next = last_level;
    upd             = 1'b0;
    norm            = '0;
    case (action_t'(act))
      ACT_RESTART: begin
        ph_next      = PH_DETECT;
        count_next   = '0;
        sum_next     = '0;
        run_min_next = MIN_RST;
        run_max_next = '0;
      end
      ACT_MANUAL: begin
        bound_low_next  = man_lo;
        bound_high_next = man_hi;
      end
      ACT_SAMPLE: begin
        case (ph)
          PH_DETECT: begin
            sum_next   = sum_add;
            count_next = cnt_inc;
            if (det_end) begin
              last_level_next = avg;
              count_next      = '0;
              sum_next        = '0;
              run_min_next    = MIN_RST;
              run_max_next    = '0;
              if (avg >= cfg.detect_threshold) begin
                ph_next = PH_CALIB;
              end else begin
                ph_next         = PH_NONE;
                bound_low_next  = '0;
                bound_high_next = cfg.default_max;
              end
            end
          end
          PH_CALIB: begin
            sum_next     = sum_add;
            count_next   = cnt_inc;
            run_min_next = min_new;
            run_max_next = max_new;
            if (cal_end) begin
              if ((min_new > cfg.calib_floor) && (spread > cfg.calib_span)) begin
                bound_low_next  = BOUND_W'(min_new);
                bound_high_next = BOUND_W'(max_new);
              end else begin
                bound_low_next  = '0;
                bound_high_next = cfg.default_max;
              end
              last_level_next = avg;
              count_next      = '0;
              sum_next        = '0;
              run_min_next    = MIN_RST;
              run_max_next    = '0;
              ph_next         = PH_RUN;
            end
          end
          PH_RUN: begin
            last_level_next = smp;
            upd             = 1'b1;
            if (range == '0) begin
              norm = NORM_MID;
            end else if (!above_low) begin
              norm = '0;
            end else if (!run_div) begin
              norm = NORM_FULL;
            end else begin
              norm = quot;
            end
          end
          default: begin
            // not connected: drop the sample
          end
        endcase
      end
      default: begin
        // unused action code: report state only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action;
      smp    <= sample;
      man_lo <= manual_low;
      man_hi <= manual_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph         <= PH_DETECT;
      count      <= '0;
      sum        <= '0;
      run_min    <= MIN_RST;
      run_max    <= '0;
      bound_low  <= '0;
      bound_high <= DEFMAX_RST;
      last_level <= '0;
    end else if (cmd.commit) begin
      ph         <= ph_next;
      count      <= count_next;
      sum        <= sum_next;
      run_min    <= run_min_next;
      run_max    <= run_max_next;
      bound_low  <= bound_low_next;
      bound_high <= bound_high_next;
      last_level <= last_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      phase        <= ph_next;
      connected    <= (ph_next == PH_CALIB) || (ph_next == PH_RUN);
      updated      <= upd;
      level        <= last_level_next;
      normalized   <= norm;
      pupil_factor <= upd ? ~norm : '0;
    end
  end

endmodule

// File: src/light_sensor_detect_calibrate_normalize.sv
// ----------------------------------------------------------------------------
// light_sensor_detect_calibrate_normalize
// Light sensor detection, min/max calibration and Q0.16 normalization.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        carries
//   item      in         valid / ready    action, sample, manual bounds
//   result    out        valid / ready    phase, flags, level, normalized, pupil
//   apb       in         psel / penable   four configuration registers
//
// An item that needs a division (the last detection or calibration sample,
// or a running sample inside the bounds) goes through the 16-step radix-2
// divider shared by the average and the normalization; every other item
// skips the divider.
// The next item is taken once the current result sits in the output
// register; a stalled result holds the block in its commit step.
// Reset (rst, synchronous) restores detection, default bounds and registers.
//
`include "light_sensor_detect_calibrate_normalize_macros.svh"

module light_sensor_detect_calibrate_normalize
  import lsdcn_pkg::*;
#(
  parameter int DETECT_SAMPLES = 8,
  parameter int CALIB_SAMPLES  = 16
) (
  input  logic              clk,
  input  logic              rst,
  lsdcn_item_if.sink        item,
  lsdcn_result_if.source    result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     cfg_write;
  reg_idx_t reg_idx;

  // Configuration registers: written in the APB access phase, never stalled.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_threshold <= THRESHOLD_RST;
      cfg.calib_floor      <= FLOOR_RST;
      cfg.calib_span       <= SPAN_RST;
      cfg.default_max      <= DEFMAX_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_DETECT_THRESHOLD: cfg.detect_threshold <= pwdata[SAMPLE_W-1:0];
        REG_CALIB_FLOOR:      cfg.calib_floor      <= pwdata[SAMPLE_W-1:0];
        REG_CALIB_SPAN:       cfg.calib_span       <= pwdata[SAMPLE_W-1:0];
        REG_DEFAULT_MAX:      cfg.default_max      <= pwdata[BOUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (reg_idx)
      REG_DETECT_THRESHOLD: prdata = DATA_W'(cfg.detect_threshold);
      REG_CALIB_FLOOR:      prdata = DATA_W'(cfg.calib_floor);
      REG_CALIB_SPAN:       prdata = DATA_W'(cfg.calib_span);
      REG_DEFAULT_MAX:      prdata = DATA_W'(cfg.default_max);
      default:              prdata = '0;
    endcase
  end

  // Sequencer: accept, optionally divide, then commit into the result register.
  lsdcn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: sensor state, bounds, divider and the result payload.
  lsdcn_dp #(
    .DETECT_SAMPLES (DETECT_SAMPLES),
    .CALIB_SAMPLES  (CALIB_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .action       (item.action),
    .sample       (item.sample),
    .manual_low   (item.manual_low),
    .manual_high  (item.manual_high),
    .phase        (result.phase),
    .connected    (result.connected),
    .updated      (result.updated),
    .level        (result.level),
    .normalized   (result.normalized),
    .pupil_factor (result.pupil_factor)
  );

  // A result reports connected only in the calibrating or running phase.
  `LSDCN_ASSERT_IMPL(a_top_connected, clk, rst, result.valid,
                     result.connected == (result.phase == PH_CALIB || result.phase == PH_RUN),
                     "connected flag disagrees with phase")
  // Normalized and pupil factor always add up to full scale when updated.
  `LSDCN_ASSERT_IMPL(a_top_pupil, clk, rst, result.valid && result.updated,
                     (result.normalized ^ result.pupil_factor) == NORM_FULL,
                     "pupil factor not complement of normalized")
  // No new item is taken while one is in flight.
  `LSDCN_ASSERT_NEXT(a_top_one_item, clk, rst, item.valid && item.ready, !item.ready,
                     "second item taken while busy")

endmodule
